[design/ebmd_pkg.sv]
// ----------------------------------------------------------------------------
// ebmd_pkg
// Shared types and constants of the echo burst median distance block.
// ----------------------------------------------------------------------------
package ebmd_pkg;

    // Field widths
    localparam int ECHO_W  = 20;
    localparam int CM_W    = 15;
    localparam int COUNT_W = 6;

    typedef logic [ECHO_W-1:0]  echo_us_t;
    typedef logic [CM_W-1:0]    median_cm_t;
    typedef logic [COUNT_W-1:0] count_cfg_t;

    // Samples per burst after reset
    localparam count_cfg_t SAMPLE_COUNT_RESET = 6'd24;

    // Round trip: 29 us per cm each way, so divide the echo width by 58.
    localparam int US_PER_CM   = 29;
    localparam int TRIP_DIV    = 2;
    localparam int CM_DIVISOR  = US_PER_CM * TRIP_DIV;

    // Reciprocal multiply: ceil(2^26 / 58) is exact for every 20-bit width
    localparam int DIV_SHIFT = 26;
    localparam int MULT_W    = 21;
    localparam int PROD_W    = ECHO_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR);

endpackage

[design/ebmd_echo_if.sv]
// ----------------------------------------------------------------------------
// ebmd_echo_if
// Request channel carrying one echo pulse width in microseconds.
// ----------------------------------------------------------------------------
interface ebmd_echo_if;

    logic               valid;
    logic               ready;
    ebmd_pkg::echo_us_t echo_us;

    modport source (output valid, output echo_us, input ready);
    modport sink   (input valid, input echo_us, output ready);

endinterface

[design/ebmd_median_if.sv]
// ----------------------------------------------------------------------------
// ebmd_median_if
// Request channel carrying one burst median distance in centimetres.
// ----------------------------------------------------------------------------
interface ebmd_median_if;

    logic                 valid;
    logic                 ready;
    ebmd_pkg::median_cm_t median_cm;

    modport source (output valid, output median_cm, input ready);
    modport sink   (input valid, input median_cm, output ready);

endinterface

[design/ebmd_ram.sv]
// ----------------------------------------------------------------------------
// ebmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ebmd_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/ebmd_cm_conv.sv]
// ----------------------------------------------------------------------------
// ebmd_cm_conv
// Converts an echo width in microseconds to centimetres, floor(us / 58),
// by a registered reciprocal multiply; result in the cycle after the start.
// ----------------------------------------------------------------------------
module ebmd_cm_conv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ebmd_pkg::echo_us_t   echo_us,
    output logic                 done,
    output ebmd_pkg::median_cm_t median_cm
);

    logic [ebmd_pkg::PROD_W-1:0] prod_reg;
    logic                        done_reg;

    // Multiply by the scaled reciprocal
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= ebmd_pkg::PROD_W'(echo_us) * ebmd_pkg::PROD_W'(ebmd_pkg::DIV_MULT);
        end
    end

    // Flag the product in the cycle after the start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    assign done      = done_reg;
    assign median_cm = prod_reg[ebmd_pkg::DIV_SHIFT +: ebmd_pkg::CM_W];

endmodule

[design/echo_burst_median_distance.sv]
// Flow: a sample that does not close its burst passes through S_CONV and is back in S_IDLE,
// ready for the next request. The closing sample then ranks each candidate in turn over
// the single RAM read port, through S_CAND, S_LATCH and a scan of all n samples in S_SCAN.
// A new sample is taken only in S_IDLE, not while one converts or a burst is being ranked;
// the next burst opens in the same cycle as the median is offered. Reset: sample count
// back to 24, burst counter cleared, sample RAM left uninitialized.
// ----------------------------------------------------------------------------
// echo_burst_median_distance
// Stores converted echo distances in a RAM and, when the burst is full,
// finds the element of rank floor(n/2) by counting ranks over the RAM.
// ----------------------------------------------------------------------------
module echo_burst_median_distance #(
    parameter int MAX_SAMPLES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ebmd_echo_if.sink            echo,
    ebmd_median_if.source        median,
    input  logic                 cfg_we,
    input  ebmd_pkg::count_cfg_t cfg_wdata
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1) > 0 ? $clog2(MAX_SAMPLES + 1) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_CAND  = 3'd2;
    localparam logic [2:0] S_LATCH = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]           state_reg, state_next;
    ebmd_pkg::count_cfg_t cfg_reg;
    logic [CW-1:0]        taken_reg, taken_next;
    logic [AW-1:0]        cand_idx_reg, cand_idx_next;
    logic [AW-1:0]        scan_idx_reg, scan_idx_next;
    logic [CW-1:0]        rank_reg, rank_next;
    ebmd_pkg::median_cm_t cand_val_reg;
    logic                 out_valid_reg, out_valid_next;
    ebmd_pkg::median_cm_t median_reg;

    logic [CW-1:0]        n_eff;
    logic [CW-1:0]        k_eff;
    logic [CW-1:0]        slot;
    logic [CW-1:0]        rank_sum;
    logic                 scan_last;
    logic                 contrib;
    logic                 emit_load;

    logic                 conv_start;
    logic                 conv_done;
    ebmd_pkg::median_cm_t conv_cm;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    ebmd_pkg::median_cm_t ram_rdata;

    // Clamp the configured count into 1..MAX_SAMPLES
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (int'(cfg_reg) > MAX_SAMPLES)
        begin
            n_eff = CW'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = CW'(cfg_reg);
        end
    end

    assign k_eff = n_eff >> 1;
    assign slot  = (taken_reg >= n_eff) ? (n_eff - CW'(1)) : taken_reg;

    // Rank contribution of the element now on the read port
    assign contrib   = (ram_rdata < cand_val_reg) ||
                       ((ram_rdata == cand_val_reg) && (scan_idx_reg < cand_idx_reg));
    assign rank_sum  = rank_reg + CW'(contrib);
    assign scan_last = (CW'(scan_idx_reg) == (n_eff - CW'(1)));

    assign echo.ready = (state_reg == S_IDLE);
    assign conv_start = echo.valid && echo.ready;
    assign ram_we     = (state_reg == S_CONV) && conv_done;
    assign emit_load  = (state_reg == S_EMIT) && (!out_valid_reg || median.ready);

    // Read address for the candidate fetch and the scan
    always_comb
    begin
        unique case (state_reg)
            S_CAND:  ram_raddr = cand_idx_reg;
            S_SCAN:  ram_raddr = scan_idx_reg + AW'(1);
            default: ram_raddr = '0;
        endcase
    end

    ebmd_cm_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (conv_start),
        .echo_us   (echo.echo_us),
        .done      (conv_done),
        .median_cm (conv_cm)
    );

    ebmd_ram #(
        .WIDTH (ebmd_pkg::CM_W),
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot[AW-1:0]),
        .wdata (conv_cm),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence: store the sample, then rank each candidate until the median
    always_comb
    begin
        state_next    = state_reg;
        taken_next    = taken_reg;
        cand_idx_next = cand_idx_reg;
        scan_idx_next = scan_idx_reg;
        rank_next     = rank_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (conv_start)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    if (slot + CW'(1) >= n_eff)
                    begin
                        taken_next    = '0;
                        cand_idx_next = '0;
                        state_next    = S_CAND;
                    end
                    else
                    begin
                        taken_next = slot + CW'(1);
                        state_next = S_IDLE;
                    end
                end
            end
            S_CAND:
            begin
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                scan_idx_next = '0;
                rank_next     = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                rank_next = rank_sum;
                if (scan_last)
                begin
                    if (rank_sum == k_eff)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cand_idx_next = cand_idx_reg + AW'(1);
                        state_next    = S_CAND;
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output request until taken
    always_comb
    begin
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (median.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= ebmd_pkg::SAMPLE_COUNT_RESET;
            taken_reg     <= '0;
            cand_idx_reg  <= '0;
            scan_idx_reg  <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            taken_reg     <= taken_next;
            cand_idx_reg  <= cand_idx_next;
            scan_idx_reg  <= scan_idx_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LATCH)
        begin
            cand_val_reg <= ram_rdata;
        end
        if (emit_load)
        begin
            median_reg <= cand_val_reg;
        end
    end

    assign median.valid     = out_valid_reg;
    assign median.median_cm = median_reg;

    // Conversion result comes back in the cycle after its request
    a_conv_latency: assert property (@(posedge clk) disable iff (!rst_n)
        conv_start |=> conv_done)
        else $error("conversion done missing after request");

    // Scan never runs past the burst
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(scan_idx_reg) < n_eff))
        else $error("scan index beyond burst");

    // Some candidate must match the median rank before candidates run out
    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAND) |-> (CW'(cand_idx_reg) < n_eff))
        else $error("no candidate matched the median rank");

    // A result is only pending after a completed scan
    a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_EMIT) |-> ($past(state_reg) == S_SCAN))
        else $error("emit entered without a scan");

endmodule

[bench/ebmd_median_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebmd_median_checker
// Watches the echo and median channels and the count register port, keeps
// its own copy of the burst state, predicts each burst median and compares
// it with the block's output. Hands the failure and due counts to the top.
// ----------------------------------------------------------------------------
module ebmd_median_checker #(
    parameter int MAX_SAMPLES = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   echo_valid,
    input  logic                   echo_ready,
    input  ebmd_pkg::echo_us_t     echo_us,
    input  logic                   median_valid,
    input  logic                   median_ready,
    input  ebmd_pkg::median_cm_t   median_cm,
    input  logic                   cfg_we,
    input  ebmd_pkg::count_cfg_t   cfg_wdata,
    output int                     fail_count,
    output int                     due_count
);

    ebmd_pkg::count_cfg_t burst_len_cfg;
    ebmd_pkg::median_cm_t burst_cm [MAX_SAMPLES];
    int unsigned          burst_fill;
    ebmd_pkg::median_cm_t median_due [$];
    int                   fails;

    // Convert an echo width to a one-way distance
    function automatic ebmd_pkg::median_cm_t echo_to_cm(input ebmd_pkg::echo_us_t us);
        int unsigned cm;
        cm = (int'(us) / ebmd_pkg::US_PER_CM) / ebmd_pkg::TRIP_DIV;
        return ebmd_pkg::median_cm_t'(cm);
    endfunction

    // Sort the first n distances of the burst and pick rank n/2
    function automatic ebmd_pkg::median_cm_t burst_median(input int unsigned n);
        ebmd_pkg::median_cm_t sorted [MAX_SAMPLES];
        ebmd_pkg::median_cm_t v;
        int unsigned          i;
        int unsigned          j;
        for (i = 0; i < n; i++)
            sorted[i] = burst_cm[i];
        for (i = 1; i < n; i++)
        begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n/2];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned          n;
        int unsigned          slot;
        ebmd_pkg::median_cm_t want;
        if (!rst_n)
        begin
            burst_len_cfg = ebmd_pkg::SAMPLE_COUNT_RESET;
            burst_fill    = 0;
            median_due.delete();
            fails         = 0;
            fail_count   <= 0;
            due_count    <= 0;
        end
        else
        begin
            // Track the count register
            if (cfg_we)
                burst_len_cfg = cfg_wdata;

            // Compare a delivered median with the oldest prediction
            if (median_valid && median_ready)
            begin
                if (median_due.size() == 0)
                begin
                    $display("%0t: median with none due: expected none, actual %0d",
                             $realtime, median_cm);
                    fails++;
                end
                else
                begin
                    want = median_due.pop_front();
                    if (median_cm !== want)
                    begin
                        $display("%0t: median_cm mismatch: expected %0d, actual %0d",
                                 $realtime, want, median_cm);
                        fails++;
                    end
                end
            end

            // Store an accepted sample; close the burst when it is full
            if (echo_valid && echo_ready)
            begin
                n = burst_len_cfg;
                if (n < 1)
                    n = 1;
                if (n > MAX_SAMPLES)
                    n = MAX_SAMPLES;
                // A count lowered below the fill level lands on the last slot
                slot = (burst_fill >= n) ? n - 1 : burst_fill;
                burst_cm[slot] = echo_to_cm(echo_us);
                burst_fill = slot + 1;
                if (burst_fill >= n)
                begin
                    median_due.push_back(burst_median(n));
                    burst_fill = 0;
                end
            end

            fail_count <= fails;
            due_count  <= median_due.size();
        end
    end

endmodule

[bench/tb_echo_burst_median_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_echo_burst_median_distance
// Drives echo samples through several burst lengths, including zero, one,
// the store depth and values above it, with random idling on both
// channels. The median checker predicts and compares every burst result.
// ----------------------------------------------------------------------------
module tb_echo_burst_median_distance;

    localparam int MAX_SAMPLES  = 32;
    localparam int SETTLE_WAIT  = 16;
    localparam int TAIL_WAIT    = 64;
    localparam int STALL_LIMIT  = 6000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_AFTER   = 1000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    ebmd_pkg::count_cfg_t cfg_wdata;
    int                   fail_count;
    int                   due_count;
    int                   idle_pct;
    int                   stall_left;
    int                   quiet_cycles;

    ebmd_echo_if   echo_ch ();
    ebmd_median_if median_ch ();

    echo_burst_median_distance #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .echo      (echo_ch),
        .median    (median_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ebmd_median_checker #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .echo_valid   (echo_ch.valid),
        .echo_ready   (echo_ch.ready),
        .echo_us      (echo_ch.echo_us),
        .median_valid (median_ch.valid),
        .median_ready (median_ch.ready),
        .median_cm    (median_ch.median_cm),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .due_count    (due_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Median sink: drop ready in random stall bursts
    initial
    begin
        median_ch.ready = 1'b0;
        stall_left      = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                median_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                median_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                median_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((echo_ch.valid && echo_ch.ready) || (median_ch.valid && median_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_echo_burst_median_distance: errors");
            $finish;
        end
    end

    // Pick an echo width: full range, in-spec range, duplicates or boundaries
    function automatic ebmd_pkg::echo_us_t echo_pick();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return ebmd_pkg::echo_us_t'($urandom());
            4, 5, 6:    return ebmd_pkg::echo_us_t'($urandom_range(0, 1000000));
            7:          return ebmd_pkg::echo_us_t'($urandom_range(0, 400));
            8:          return ebmd_pkg::echo_us_t'(
                            ebmd_pkg::CM_DIVISOR * $urandom_range(0, 18078)
                            + $urandom_range(0, 1) * (ebmd_pkg::CM_DIVISOR - 1));
            default:    return ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
    endfunction

    // Pick a burst length: mostly short, sometimes zero, full or above the store
    function automatic ebmd_pkg::count_cfg_t count_pick();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0:          return ebmd_pkg::count_cfg_t'(0);
            1:          return ebmd_pkg::count_cfg_t'(MAX_SAMPLES);
            2:          return ebmd_pkg::count_cfg_t'($urandom_range(MAX_SAMPLES + 1, 63));
            3:          return '1;
            4:          return ebmd_pkg::SAMPLE_COUNT_RESET;
            5, 6, 7:    return ebmd_pkg::count_cfg_t'($urandom_range(9, MAX_SAMPLES - 1));
            default:    return ebmd_pkg::count_cfg_t'($urandom_range(1, 8));
        endcase
    endfunction

    // Send one request on the echo channel, with an optional leading gap
    task automatic send_echo(input ebmd_pkg::echo_us_t us);
        int gap;
        gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            echo_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        echo_ch.valid   <= 1'b1;
        echo_ch.echo_us <= us;
        do
            @(posedge clk);
        while (!echo_ch.ready);
    endtask

    // Drop valid and wait until every due median has left and the block is idle
    task automatic drain();
        echo_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Write the burst length register
    task automatic set_count(input ebmd_pkg::count_cfg_t value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Run a burst length with a number of random samples
    task automatic run_phase(input ebmd_pkg::count_cfg_t value, input int items,
                             inout int sent);
        drain();
        set_count(value);
        if (sent >= CALM_AFTER)
            idle_pct = 0;
        else
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
        for (int k = 0; k < items; k++)
            send_echo(echo_pick());
        sent += items;
    endtask

    // Directed widths for the reset length of 24: one full burst
    ebmd_pkg::echo_us_t directed [24] = '{
        20'd0, 20'd1, 20'd28, 20'd29, 20'd57, 20'd58, 20'd59, 20'd115,
        20'd116, 20'd1000000, 20'hFFFFF, 20'hFFFFE, 20'd999999, 20'd524288,
        20'd5800, 20'd5800, 20'd5857, 20'd5858, 20'd262143, 20'd131072,
        20'd58, 20'd0, 20'hFFFFF, 20'd3000
    };

    ebmd_pkg::count_cfg_t opening [6] = '{6'd0, 6'd1, 6'd2, 6'd63, 6'd33, 6'd32};

    initial
    begin
        int sent;
        echo_ch.valid   = 1'b0;
        echo_ch.echo_us = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        idle_pct        = 0;
        sent            = 0;
        rst_n           = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed burst at the reset length
        idle_pct = 20;
        foreach (directed[k])
            send_echo(directed[k]);

        // Extreme lengths first; all but zero and one are left mid-burst for the next one
        foreach (opening[k])
            run_phase(opening[k], (opening[k] == 6'd32) ? 45 : 11, sent);

        // Random lengths and widths
        while (sent < RANDOM_ITEMS)
            run_phase(count_pick(), $urandom_range(5, 60), sent);

        // Let the last median out and watch for strays
        drain();
        repeat (TAIL_WAIT) @(posedge clk);

        if (fail_count == 0 && due_count == 0)
            $display("tb_echo_burst_median_distance: clean");
        else
            $display("tb_echo_burst_median_distance: errors");
        $finish;
    end

endmodule
